### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, held off by rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// plain property check
`define CPHS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define CPHS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define CPHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define CPHS_ASSERT(lbl, prop)
`define CPHS_ASSERT_IMPL(lbl, ante, cons)
`define CPHS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/cphs_pkg.sv
// ---------------------------------------------------------------------------
// cphs_pkg
// types and constants for the charge profile hysteresis select block
// ---------------------------------------------------------------------------
`default_nettype none

package cphs_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_CHARGE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_MIN_C       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_MAX_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW_MV        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH_MV       = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic              RST_FAST_CHARGE_ENABLE = 1'b1;
    localparam logic signed [7:0] RST_CHARGE_MIN_C       = 8'sd5;
    localparam logic signed [7:0] RST_CHARGE_MAX_C       = 8'sd48;
    localparam logic [15:0]       RST_VOLT_LOW_MV        = 16'd4130;
    localparam logic [15:0]       RST_VOLT_HIGH_MV       = 16'd4150;

    // temperature arithmetic, tenths of a degree
    localparam int unsigned TEMP_W = 18;
    localparam logic signed [TEMP_W-1:0] KELVIN_OFFSET_DECI = 18'sd2731;
    localparam logic signed [TEMP_W-1:0] T_BAND0_BELOW = 18'sd99;
    localparam logic signed [TEMP_W-1:0] T_BAND1_LO    = 18'sd101;
    localparam logic signed [TEMP_W-1:0] T_BAND1_HI    = 18'sd149;
    localparam logic signed [TEMP_W-1:0] T_BAND2_LO    = 18'sd151;
    localparam logic signed [TEMP_W-1:0] T_BAND2_HI    = 18'sd229;
    localparam logic signed [TEMP_W-1:0] T_BAND3_LO    = 18'sd231;
    localparam logic signed [TEMP_W-1:0] T_BAND3_HI    = 18'sd449;
    localparam logic signed [TEMP_W-1:0] T_BAND4_ABOVE = 18'sd451;

    // temperature band codes
    localparam logic [2:0] BAND_COLD  = 3'd0;
    localparam logic [2:0] BAND_COOL  = 3'd1;
    localparam logic [2:0] BAND_MILD  = 3'd2;
    localparam logic [2:0] BAND_WARM  = 3'd3;
    localparam logic [2:0] BAND_HOT   = 3'd4;
    localparam logic [2:0] BAND_RESET = BAND_MILD;

    // band profile table
    localparam logic [15:0] CUR_COLD_MA      = 16'd900;
    localparam logic [15:0] CUR_COOL_MA      = 16'd2700;
    localparam logic [15:0] CUR_MILD_MA      = 16'd6300;
    localparam logic [15:0] CUR_WARM_MA      = 16'd9000;
    localparam logic [15:0] CUR_HIGH_V_MA    = 16'd4500;
    localparam logic [15:0] VOL_NORMAL_MV    = 16'd4350;
    localparam logic [15:0] VOL_HOT_MV       = 16'd4150;

    typedef struct packed {
        logic              fast_charge_enable;
        logic signed [7:0] charge_min_c;
        logic signed [7:0] charge_max_c;
        logic [15:0]       volt_low_mv;
        logic [15:0]       volt_high_mv;
    } cfg_t;

    typedef struct packed {
        logic [15:0] temp_deci_kelvin;
        logic [15:0] voltage_mv;
        logic        bad_temperature;
        logic        bad_voltage;
        logic        charging;
        logic [15:0] current_in_ma;
        logic [15:0] voltage_in_mv;
    } in_item_t;

    typedef struct packed {
        logic [15:0] current_out_ma;
        logic [15:0] voltage_out_mv;
        logic        temp_blocked;
        logic        overridden;
    } out_item_t;

endpackage

`default_nettype wire

### sv/cphs_if.sv
// ---------------------------------------------------------------------------
// cphs_if
// handshake channels: battery reports in, charge requests out, config writes
// ---------------------------------------------------------------------------
`default_nettype none

interface cphs_report_if;
    logic                valid;
    logic                ready;
    cphs_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cphs_request_if;
    logic                valid;
    logic                ready;
    cphs_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cphs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cphs_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [cphs_pkg::CFG_DATA_W-1:0]     wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### sv/cphs_cfg_regs.sv
// ---------------------------------------------------------------------------
// cphs_cfg_regs
// configuration register file, always ready, unknown indexes ignored
// ---------------------------------------------------------------------------
`default_nettype none

module cphs_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    cphs_cfg_if.sink          cfg,
    output cphs_pkg::cfg_t    cfg_q
);

    cphs_pkg::cfg_t cfg_reg;
    cphs_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // decode one write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                cphs_pkg::REG_FAST_CHARGE_ENABLE: cfg_next.fast_charge_enable = cfg.wdata[0];
                cphs_pkg::REG_CHARGE_MIN_C:       cfg_next.charge_min_c = signed'(cfg.wdata[7:0]);
                cphs_pkg::REG_CHARGE_MAX_C:       cfg_next.charge_max_c = signed'(cfg.wdata[7:0]);
                cphs_pkg::REG_VOLT_LOW_MV:        cfg_next.volt_low_mv  = cfg.wdata;
                cphs_pkg::REG_VOLT_HIGH_MV:       cfg_next.volt_high_mv = cfg.wdata;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_charge_enable <= cphs_pkg::RST_FAST_CHARGE_ENABLE;
            cfg_reg.charge_min_c       <= cphs_pkg::RST_CHARGE_MIN_C;
            cfg_reg.charge_max_c       <= cphs_pkg::RST_CHARGE_MAX_C;
            cfg_reg.volt_low_mv        <= cphs_pkg::RST_VOLT_LOW_MV;
            cfg_reg.volt_high_mv       <= cphs_pkg::RST_VOLT_HIGH_MV;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### sv/cphs_band_select.sv
// ---------------------------------------------------------------------------
// cphs_band_select
// window check, temperature and voltage band hysteresis, profile override
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cphs_band_select (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 upd_en,
    input  wire cphs_pkg::cfg_t       cfg_q,
    input  wire cphs_pkg::in_item_t   item,
    output cphs_pkg::out_item_t       result
);

    localparam int unsigned TW = cphs_pkg::TEMP_W;

    logic [2:0]            band_reg;
    logic [2:0]            band_next;
    logic                  vhigh_reg;
    logic                  vhigh_next;
    logic signed [TW-1:0]  temp_dc;
    logic signed [TW-1:0]  min_ext;
    logic signed [TW-1:0]  max_ext;
    logic signed [TW-1:0]  min_deci;
    logic signed [TW-1:0]  max_deci;
    logic                  blocked;

    // kelvin to celsius, window limits times ten
    always_comb
    begin
        temp_dc  = signed'({2'b00, item.temp_deci_kelvin}) - cphs_pkg::KELVIN_OFFSET_DECI;
        min_ext  = TW'(cfg_q.charge_min_c);
        max_ext  = TW'(cfg_q.charge_max_c);
        min_deci = (min_ext <<< 3) + (min_ext <<< 1);
        max_deci = (max_ext <<< 3) + (max_ext <<< 1);
        blocked  = !item.bad_temperature && ((temp_dc >= max_deci) || (temp_dc < min_deci));
    end

    // temperature band with dead zones between bands
    always_comb
    begin
        band_next = band_reg;
        if (!blocked && !item.bad_temperature)
        begin
            priority if (temp_dc < cphs_pkg::T_BAND0_BELOW)
                band_next = cphs_pkg::BAND_COLD;
            else if (temp_dc > cphs_pkg::T_BAND1_LO && temp_dc < cphs_pkg::T_BAND1_HI)
                band_next = cphs_pkg::BAND_COOL;
            else if (temp_dc > cphs_pkg::T_BAND2_LO && temp_dc < cphs_pkg::T_BAND2_HI)
                band_next = cphs_pkg::BAND_MILD;
            else if (temp_dc > cphs_pkg::T_BAND3_LO && temp_dc < cphs_pkg::T_BAND3_HI)
                band_next = cphs_pkg::BAND_WARM;
            else if (temp_dc > cphs_pkg::T_BAND4_ABOVE)
                band_next = cphs_pkg::BAND_HOT;
            else
                band_next = band_reg;
        end
    end

    // voltage band, low test wins
    always_comb
    begin
        vhigh_next = vhigh_reg;
        if (!blocked && !item.bad_voltage)
        begin
            priority if (item.voltage_mv < cfg_q.volt_low_mv)
                vhigh_next = 1'b0;
            else if (item.voltage_mv > cfg_q.volt_high_mv)
                vhigh_next = 1'b1;
            else
                vhigh_next = vhigh_reg;
        end
    end

    // profile table or pass-through
    always_comb
    begin
        result.current_out_ma = item.current_in_ma;
        result.voltage_out_mv = item.voltage_in_mv;
        result.temp_blocked   = 1'b0;
        result.overridden     = 1'b0;
        if (blocked)
        begin
            result.current_out_ma = '0;
            result.voltage_out_mv = '0;
            result.temp_blocked   = 1'b1;
        end
        else if (item.charging && cfg_q.fast_charge_enable)
        begin
            result.overridden     = 1'b1;
            result.voltage_out_mv = cphs_pkg::VOL_NORMAL_MV;
            unique case (band_next)
                cphs_pkg::BAND_COLD: result.current_out_ma = cphs_pkg::CUR_COLD_MA;
                cphs_pkg::BAND_COOL: result.current_out_ma = cphs_pkg::CUR_COOL_MA;
                cphs_pkg::BAND_MILD: result.current_out_ma =
                    vhigh_next ? cphs_pkg::CUR_HIGH_V_MA : cphs_pkg::CUR_MILD_MA;
                cphs_pkg::BAND_WARM: result.current_out_ma =
                    vhigh_next ? cphs_pkg::CUR_HIGH_V_MA : cphs_pkg::CUR_WARM_MA;
                cphs_pkg::BAND_HOT:
                begin
                    result.current_out_ma = cphs_pkg::CUR_HIGH_V_MA;
                    result.voltage_out_mv = cphs_pkg::VOL_HOT_MV;
                end
                default:
                begin
                    result.overridden     = 1'b0;
                    result.current_out_ma = item.current_in_ma;
                    result.voltage_out_mv = item.voltage_in_mv;
                end
            endcase
        end
    end

    // band state, moves only when a report leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg  <= cphs_pkg::BAND_RESET;
            vhigh_reg <= 1'b0;
        end
        else if (upd_en)
        begin
            band_reg  <= band_next;
            vhigh_reg <= vhigh_next;
        end
    end

    // band code never leaves the five defined bands
    `CPHS_ASSERT(a_band_valid, band_reg <= cphs_pkg::BAND_HOT)
    // no report processed, no band movement
    `CPHS_ASSERT_NEXT(a_band_hold, !upd_en, $stable(band_reg) && $stable(vhigh_reg))
    // a blocked report leaves both bands alone
    `CPHS_ASSERT_NEXT(a_blocked_keeps, upd_en && blocked, $stable(band_reg) && $stable(vhigh_reg))

endmodule

`default_nettype wire

### sv/charge_profile_hysteresis_select.sv
// ---------------------------------------------------------------------------
// charge_profile_hysteresis_select
// per-report charge request selection with temperature and voltage bands
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                                   beat per cycle
//  report    in   temp, voltage, bad flags, charging, reqs  1
//  request   out  current, voltage, temp_blocked, overridden 1
//  cfg       in   reg_index, wdata                          1, always ready
//
//  one report beat per cycle unless the request side stalls; request valid
//  after the report passes the input register, then the band logic into the
//  output register
//  bands update as a report moves from input to output register
//  reset: bands to the 15 to 23 C band and low voltage, config to defaults
//  a stalled request holds the output; the input register still refills
//  while the output waits, then report.ready drops
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module charge_profile_hysteresis_select (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cphs_report_if.sink     report,
    cphs_request_if.source  request,
    cphs_cfg_if.sink        cfg
);

    cphs_pkg::cfg_t       cfg_q;
    cphs_pkg::in_item_t   s1_item_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    cphs_pkg::out_item_t  out_item_reg;
    cphs_pkg::out_item_t  result;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 s1_adv;
    logic                 report_take;

    cphs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    cphs_band_select u_band_select (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (s1_adv),
        .cfg_q  (cfg_q),
        .item   (s1_item_reg),
        .result (result)
    );

    // pipeline handshake
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || request.ready);
    assign report.ready = !s1_valid_reg || s1_adv;
    assign report_take  = report.valid && report.ready;

    assign request.valid = out_valid_reg;
    assign request.data  = out_item_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (report_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (request.ready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (report_take)
            s1_item_reg <= report.data;
        if (s1_adv)
            out_item_reg <= result;
    end

    // empty output stage never holds back the input
    `CPHS_ASSERT_IMPL(a_ready_when_empty, !out_valid_reg, report.ready)
    // a processed report always lands in the output register
    `CPHS_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg)
    // blocked results carry zero requests and no override
    `CPHS_ASSERT_IMPL(a_blocked_zero, out_valid_reg && out_item_reg.temp_blocked,
        !out_item_reg.overridden && out_item_reg.current_out_ma == '0
        && out_item_reg.voltage_out_mv == '0)

endmodule

`default_nettype wire

### bench/cphs_checker.sv
// ---------------------------------------------------------------------------
// cphs_checker
// watches the report, request and config channels of the charge profile
// block, keeps its own copy of the band state and registers, predicts the
// request for every accepted report and compares it with the request beats
// ---------------------------------------------------------------------------
module cphs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rpt_valid,
    input  logic                            rpt_ready,
    input  cphs_pkg::in_item_t              rpt_data,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  cphs_pkg::out_item_t             req_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cphs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cphs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // physical constants of the band profile, tenths of a degree and mA/mV
    localparam int DECI_KELVIN_AT_ZERO_C = 2731;
    localparam int COLD_MAX     = 99;
    localparam int COOL_LO      = 101;
    localparam int COOL_HI      = 149;
    localparam int MILD_LO      = 151;
    localparam int MILD_HI      = 229;
    localparam int WARM_LO      = 231;
    localparam int WARM_HI      = 449;
    localparam int HOT_MIN      = 451;
    localparam int COLD_MA      = 900;
    localparam int COOL_MA      = 2700;
    localparam int MILD_MA      = 6300;
    localparam int WARM_MA      = 9000;
    localparam int HIGH_BAND_MA = 4500;
    localparam int NORMAL_MV    = 4350;
    localparam int HOT_MV       = 4150;

    // register copy
    logic              fast_en;
    logic signed [7:0] min_c;
    logic signed [7:0] max_c;
    logic [15:0]       low_mv;
    logic [15:0]       high_mv;

    // band state copy
    logic [2:0]        temp_band;
    logic              volt_high;

    cphs_pkg::out_item_t expected_q[$];
    cphs_pkg::out_item_t want;

    // next request for one report, updating the band state as the block does
    function automatic cphs_pkg::out_item_t select_request(cphs_pkg::in_item_t r);
        cphs_pkg::out_item_t o;
        int                  t;
        t = int'(r.temp_deci_kelvin) - DECI_KELVIN_AT_ZERO_C;
        o.current_out_ma = r.current_in_ma;
        o.voltage_out_mv = r.voltage_in_mv;
        o.temp_blocked   = 1'b0;
        o.overridden     = 1'b0;
        // valid temperature outside the charge window: zero out, keep state
        if (!r.bad_temperature && (t >= int'(max_c) * 10 || t < int'(min_c) * 10))
        begin
            o.current_out_ma = '0;
            o.voltage_out_mv = '0;
            o.temp_blocked   = 1'b1;
            return o;
        end
        // temperature band with dead zones
        if (!r.bad_temperature)
        begin
            if (t < COLD_MAX)
                temp_band = cphs_pkg::BAND_COLD;
            else if (t > COOL_LO && t < COOL_HI)
                temp_band = cphs_pkg::BAND_COOL;
            else if (t > MILD_LO && t < MILD_HI)
                temp_band = cphs_pkg::BAND_MILD;
            else if (t > WARM_LO && t < WARM_HI)
                temp_band = cphs_pkg::BAND_WARM;
            else if (t > HOT_MIN)
                temp_band = cphs_pkg::BAND_HOT;
        end
        // voltage band, low test first
        if (!r.bad_voltage)
        begin
            if (r.voltage_mv < low_mv)
                volt_high = 1'b0;
            else if (r.voltage_mv > high_mv)
                volt_high = 1'b1;
        end
        // profile table override
        if (r.charging && fast_en)
        begin
            o.overridden     = 1'b1;
            o.voltage_out_mv = 16'(NORMAL_MV);
            case (temp_band)
                cphs_pkg::BAND_COLD: o.current_out_ma = 16'(COLD_MA);
                cphs_pkg::BAND_COOL: o.current_out_ma = 16'(COOL_MA);
                cphs_pkg::BAND_MILD:
                    o.current_out_ma = volt_high ? 16'(HIGH_BAND_MA) : 16'(MILD_MA);
                cphs_pkg::BAND_WARM:
                    o.current_out_ma = volt_high ? 16'(HIGH_BAND_MA) : 16'(WARM_MA);
                cphs_pkg::BAND_HOT:
                begin
                    o.current_out_ma = 16'(HIGH_BAND_MA);
                    o.voltage_out_mv = 16'(HOT_MV);
                end
                default:
                begin
                    o.overridden     = 1'b0;
                    o.current_out_ma = r.current_in_ma;
                    o.voltage_out_mv = r.voltage_in_mv;
                end
            endcase
        end
        return o;
    endfunction

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    // compare request beats, queue predictions, follow register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_en    = 1'b1;
            min_c      = 8'sd5;
            max_c      = 8'sd48;
            low_mv     = 16'd4130;
            high_mv    = 16'd4150;
            temp_band  = cphs_pkg::BAND_MILD;
            volt_high  = 1'b0;
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("request beat with no report waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("current_out_ma", want.current_out_ma, req_data.current_out_ma);
                    check_field("voltage_out_mv", want.voltage_out_mv, req_data.voltage_out_mv);
                    check_field("temp_blocked", want.temp_blocked, req_data.temp_blocked);
                    check_field("overridden", want.overridden, req_data.overridden);
                end
            end
            if (rpt_valid && rpt_ready)
                expected_q.push_back(select_request(rpt_data));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cphs_pkg::REG_FAST_CHARGE_ENABLE: fast_en = cfg_wdata[0];
                    cphs_pkg::REG_CHARGE_MIN_C:       min_c   = cfg_wdata[7:0];
                    cphs_pkg::REG_CHARGE_MAX_C:       max_c   = cfg_wdata[7:0];
                    cphs_pkg::REG_VOLT_LOW_MV:        low_mv  = cfg_wdata;
                    cphs_pkg::REG_VOLT_HIGH_MV:       high_mv = cfg_wdata;
                    default: ;
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// drives battery reports and register writes into the charge profile block
// with random gaps and stalls on both sides; the checker predicts and
// compares every request beat, this module gives the verdict
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 47;
    localparam int ZERO_C_DECI_K = 2731;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   no_gaps;
    bit   no_stalls;

    // what was last written, used to aim the temperatures and voltages
    int   cur_min;
    int   cur_max;
    int   cur_low;
    int   cur_high;

    cphs_report_if  rpt_ch ();
    cphs_request_if req_ch ();
    cphs_cfg_if     cfg_ch ();

    charge_profile_hysteresis_select dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .report  (rpt_ch),
        .request (req_ch),
        .cfg     (cfg_ch)
    );

    cphs_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .rpt_valid  (rpt_ch.valid),
        .rpt_ready  (rpt_ch.ready),
        .rpt_data   (rpt_ch.data),
        .req_valid  (req_ch.valid),
        .req_ready  (req_ch.ready),
        .req_data   (req_ch.data),
        .cfg_valid  (cfg_ch.valid),
        .cfg_ready  (cfg_ch.ready),
        .cfg_index  (cfg_ch.reg_index),
        .cfg_wdata  (cfg_ch.wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // report built from a temperature in tenths of a degree C
    function automatic cphs_pkg::in_item_t report_at(int t_deci_c, int mv, bit bad_t,
                                                     bit bad_v, bit chg, int cur_ma,
                                                     int req_mv);
        cphs_pkg::in_item_t r;
        r.temp_deci_kelvin = 16'(t_deci_c + ZERO_C_DECI_K);
        r.voltage_mv       = 16'(mv);
        r.bad_temperature  = bad_t;
        r.bad_voltage      = bad_v;
        r.charging         = chg;
        r.current_in_ma    = 16'(cur_ma);
        r.voltage_in_mv    = 16'(req_mv);
        return r;
    endfunction

    // random report, mostly inside the window or near a band edge
    function automatic cphs_pkg::in_item_t rand_report();
        cphs_pkg::in_item_t r;
        int                 t;
        int                 mv;
        int                 lo;
        int                 hi;
        int                 pick;
        lo   = cur_min * 10 - 30;
        hi   = cur_max * 10 + 30;
        pick = $urandom_range(0, 9);
        if (pick < 6 && hi > lo)
            t = lo + $urandom_range(0, hi - lo);
        else if (pick < 9)
        begin
            case ($urandom_range(0, 9))
                0: t = 99;
                1: t = 101;
                2: t = 149;
                3: t = 151;
                4: t = 229;
                5: t = 231;
                6: t = 449;
                7: t = 451;
                8: t = cur_min * 10;
                default: t = cur_max * 10;
            endcase
            t = t + $urandom_range(0, 4) - 2;
        end
        else
            t = int'(16'($urandom())) - ZERO_C_DECI_K;
        if ($urandom_range(0, 9) < 6)
        begin
            mv = ($urandom_range(0, 1) ? cur_low : cur_high) + $urandom_range(0, 8) - 4;
            if (mv < 0)
                mv = 0;
            if (mv > 65535)
                mv = 65535;
        end
        else
            mv = int'(16'($urandom()));
        r = report_at(t, mv, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                      $urandom_range(0, 3) != 0, $urandom(), $urandom());
        return r;
    endfunction

    // one report beat, after a random gap
    task automatic send_report(cphs_pkg::in_item_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            rpt_ch.valid <= 1'b0;
        end
        @(negedge clk);
        rpt_ch.valid <= 1'b1;
        rpt_ch.data  <= r;
        do
            @(posedge clk);
        while (!(rpt_ch.valid && rpt_ch.ready));
    endtask

    // stop sending and wait until every request has come back
    task automatic wait_idle();
        @(negedge clk);
        rpt_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [cphs_pkg::CFG_IDX_W-1:0] idx,
                             logic [cphs_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // full register set, junk in unused bits and unused indexes
    task automatic set_config(bit fast, int min_c, int max_c, int low_mv, int high_mv);
        wait_idle();
        write_reg(cphs_pkg::REG_FAST_CHARGE_ENABLE, {15'($urandom()), fast});
        write_reg(cphs_pkg::REG_CHARGE_MIN_C, {8'($urandom()), 8'(min_c)});
        write_reg(cphs_pkg::REG_CHARGE_MAX_C, {8'($urandom()), 8'(max_c)});
        write_reg(cphs_pkg::REG_VOLT_LOW_MV, 16'(low_mv));
        write_reg(cphs_pkg::REG_VOLT_HIGH_MV, 16'(high_mv));
        for (int i = cphs_pkg::REG_VOLT_HIGH_MV + 1; i < (1 << cphs_pkg::CFG_IDX_W); i++)
            write_reg((cphs_pkg::CFG_IDX_W)'(i), 16'($urandom()));
        cur_min  = min_c;
        cur_max  = max_c;
        cur_low  = low_mv;
        cur_high = high_mv;
    endtask

    // random reports, gaps switched off for some stretches
    task automatic run_reports(int count, int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (i == hold_at)
                wait_idle();
            send_report(rand_report());
        end
    endtask

    // request side: random stalls per beat, none in some stretches
    initial
    begin
        int stall;
        int beats;
        req_ch.ready = 1'b0;
        beats        = 0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 16 == 0)
                no_stalls = ($urandom_range(0, 3) == 0);
            stall = no_stalls ? 0 : $urandom_range(0, 7);
            repeat (stall)
            begin
                @(negedge clk);
                req_ch.ready <= 1'b0;
            end
            @(negedge clk);
            req_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(req_ch.valid && req_ch.ready));
            beats++;
        end
    end

    // stimulus and verdict
    initial
    begin
        int mn;
        int mx;
        rst_n            = 1'b0;
        rpt_ch.valid     = 1'b0;
        rpt_ch.data      = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wdata     = '0;
        no_gaps          = 1'b0;
        cur_min          = 5;
        cur_max          = 48;
        cur_low          = 4130;
        cur_high         = 4150;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: register defaults, window 5 to 48 C
        send_report(report_at(-ZERO_C_DECI_K, 4140, 0, 0, 1, 65535, 65535));
        send_report(report_at(65535 - ZERO_C_DECI_K, 4140, 0, 0, 1, 0, 0));
        send_report(report_at(-ZERO_C_DECI_K, 65535, 1, 0, 1, 1, 1));
        send_report(report_at(49, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(50, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(99, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(101, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(102, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(149, 4150, 0, 0, 1, 100, 100));
        send_report(report_at(150, 4150, 0, 0, 1, 100, 100));
        send_report(report_at(152, 4129, 0, 0, 1, 100, 100));
        send_report(report_at(229, 4130, 0, 0, 1, 100, 100));
        send_report(report_at(232, 4150, 0, 0, 1, 100, 100));
        send_report(report_at(300, 4151, 0, 0, 1, 100, 100));
        send_report(report_at(449, 0, 0, 1, 1, 100, 100));
        send_report(report_at(451, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(452, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(479, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(480, 0, 0, 0, 1, 100, 100));
        // blocked report must not touch the voltage band
        send_report(report_at(300, 0, 0, 1, 1, 100, 100));
        send_report(report_at(600, 0, 0, 0, 1, 100, 100));
        send_report(report_at(300, 4140, 0, 0, 1, 100, 100));
        send_report(report_at(300, 4140, 0, 0, 0, 12345, 54321));
        send_report(report_at(9000, 0, 1, 1, 0, 65535, 0));
        send_report(report_at(90, 65535, 0, 0, 1, 0, 65535));

        // register sets, extremes first
        set_config(0, -40, 127, 0, 65535);
        run_reports(ITEMS_PER_SET, -1);
        set_config(1, -40, 127, 4130, 4150);
        run_reports(ITEMS_PER_SET, 20);
        set_config(1, 127, -40, 4130, 4150);
        run_reports(ITEMS_PER_SET, -1);
        set_config(1, 20, 20, 5000, 3000);
        run_reports(ITEMS_PER_SET, -1);
        set_config(1, 0, 60, 65535, 0);
        run_reports(ITEMS_PER_SET, -1);
        set_config(1, -128, 127, 4000, 4300);
        run_reports(ITEMS_PER_SET, -1);
        for (int k = 0; k < 3; k++)
        begin
            mn = $urandom_range(0, 100) - 40;
            mx = mn + $urandom_range(0, 127 - mn);
            set_config($urandom_range(0, 1), mn, mx, 3900 + $urandom_range(0, 400),
                       3900 + $urandom_range(0, 400));
            run_reports(ITEMS_PER_SET, -1);
        end

        // drain and settle
        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/cphs_pkg.sv
sv/cphs_if.sv
sv/cphs_cfg_regs.sv
sv/cphs_band_select.sv
sv/charge_profile_hysteresis_select.sv
bench/cphs_checker.sv
bench/tb_top.sv
